// File: hdl/tcske_pkg.sv
`default_nettype none
package tcske_pkg;
    localparam int FRAC_BITS    = 16;
    localparam int EXP_SEGMENTS = 64;
    localparam logic [16:0] NOISE_RESET = 17'd197;

    localparam logic [1:0] CAT_NONE  = 2'd0;
    localparam logic [1:0] CAT_BERTH = 2'd1;
    localparam logic [1:0] CAT_CRANE = 2'd2;
    localparam logic [1:0] CAT_YARD  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_X,
        ST_MUL_P,
        ST_EXP,
        ST_OUT
    } t_state;

    // exp(k/SEG) as a truncated integer Taylor series at 32 fraction bits
    function automatic logic [63:0] exp_node(input logic [63:0] k, input int seg,
                                             input int fb);
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] quo;
        logic [63:0] rem;
        term = 64'd1 << 32;
        sum  = 64'd0;
        for (int n = 1; n < 64; n++) begin
            if (term != 64'd0) begin
                sum = sum + term;
                // next term: term * k over seg * n, by long division
                num = term * k;
                den = 64'(seg) * 64'(n);
                quo = '0;
                rem = '0;
                for (int b = 63; b >= 0; b--) begin
                    rem = {rem[62:0], num[b]};
                    if (rem >= den) begin
                        rem    = rem - den;
                        quo[b] = 1'b1;
                    end
                end
                term = quo;
            end
        end
        return sum >> (32 - fb);
    endfunction
endpackage
`default_nettype wire

// File: hdl/three_channel_scalar_kalman_estimator_top.sv
// Flow: a request is taken in ST_IDLE; when a channel is updated it passes ST_DIV,
// ST_MUL_X (waiting on the divider, one quotient bit a cycle), ST_MUL_P, ST_EXP and
// ST_OUT; otherwise ST_DIV, ST_EXP and ST_OUT. ST_OUT raises the result valid.
// Throughput: one request at a time, s_axis_tready low while busy or a result waits.
// Reset: synchronous active low; levels 1.0/1.0/0.5, uncertainties 0.5,
// process noise 197.
`default_nettype none
module three_channel_scalar_kalman_estimator_top #(
    parameter int EXP_SEGMENTS = tcske_pkg::EXP_SEGMENTS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [16:0]  i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // reliability[16:0], severity[33:17], yard_value[50:34], stamp[98:51], zero pad
    input  wire logic [103:0] s_axis_tdata,
    // category[1:0], has_value[2]
    input  wire logic [2:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // berth[16:0] crane[33:17] yard[50:34] throughput[67:51] delay[88:68]
    // last_stamp[136:89], zero pad
    output logic [143:0]      m_axis_tdata
);
    localparam int  FRAC_BITS = tcske_pkg::FRAC_BITS;
    localparam int  VW  = FRAC_BITS + 1;
    localparam int  PW  = FRAC_BITS + 4;
    localparam int  NW  = PW + FRAC_BITS;
    localparam int  DW  = PW + 1;
    localparam int  SW  = VW + 5 + $clog2(EXP_SEGMENTS);
    localparam logic [VW-1:0] ONE    = VW'(1) << FRAC_BITS;
    localparam logic [PW-1:0] UMAX   = {PW{1'b1}};
    localparam logic [VW-1:0] RFLOOR = VW'((64'd1 << FRAC_BITS) / 100);
    localparam logic [VW-1:0] YHI    = VW'(((64'd1 << FRAC_BITS) * 9) / 10);
    localparam int  NODES = 4 * EXP_SEGMENTS + 2;
    localparam int  IW    = $clog2(NODES);

    function automatic logic [VW-1:0] clamp1(input logic [16:0] v);
        return (VW'(v) > ONE) ? ONE : VW'(v);
    endfunction

    tcske_pkg::t_state r_state, n_state;
    logic [16:0]   r_noise;
    logic [VW-1:0] r_x [3];
    logic [PW-1:0] r_p [3];
    logic [1:0]    r_ch;
    logic          r_upd;
    logic [VW-1:0] r_z, r_r;
    logic [47:0]   r_stamp;
    logic [VW-1:0] r_k;
    logic [VW-1:0] r_thr;
    logic [20:0]   r_delay;
    logic          r_ovalid;
    logic          div_start, div_done;
    logic [NW-1:0] div_quo;
    logic [PW-1:0] p_sel;
    logic [PW:0]   p_noisy [3];
    logic [63:0]   exp_tab [NODES];

    // exp node table, constant
    for (genvar g = 0; g < NODES; g++) begin : g_exp
        localparam logic [63:0] NODE_VAL =
            tcske_pkg::exp_node(64'(g), EXP_SEGMENTS, FRAC_BITS);
        assign exp_tab[g] = NODE_VAL;
    end

    // shared multiplier operands
    logic [VW-1:0] mul_a;
    logic [PW-1:0] mul_b;
    logic [VW+PW-1:0] mul_y;
    assign mul_y = mul_a * mul_b;

    assign p_sel = r_p[r_ch];

    tcske_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num({p_sel, {FRAC_BITS{1'b0}}}), .i_den(DW'(p_sel) + DW'(r_r)),
        .o_done(div_done), .o_quo(div_quo)
    );

    logic [VW-1:0] x_sel, x_diff, ya;
    logic [SW-1:0] scaled;
    logic [IW-1:0] eidx;
    logic [FRAC_BITS-1:0] efrac;
    logic [63:0] ea, eb;
    logic [VW-1:0] x_min;

    assign x_sel  = r_x[r_ch];
    assign x_diff = (r_z >= x_sel) ? r_z - x_sel : x_sel - r_z;
    assign ya     = r_x[2] - YHI;
    assign scaled = SW'(ya) * SW'(5'd30) * SW'(EXP_SEGMENTS);

    always_comb begin
        eidx  = IW'(scaled >> FRAC_BITS);
        efrac = scaled[FRAC_BITS-1:0];
        if ((scaled >> FRAC_BITS) > SW'(4 * EXP_SEGMENTS)) begin
            eidx  = IW'(4 * EXP_SEGMENTS);
            efrac = '0;
        end
    end
    assign ea = exp_tab[eidx];
    assign eb = exp_tab[eidx + IW'(1)];

    for (genvar c = 0; c < 3; c++) begin : g_noise
        assign p_noisy[c] = {1'b0, r_p[c]} + (PW+1)'(r_noise);
    end

    // multiplier operand select per step
    always_comb begin
        mul_a = VW'(div_quo);
        mul_b = PW'(x_diff);
        case (r_state)
            tcske_pkg::ST_MUL_P: begin
                mul_a = ONE - r_k;
                mul_b = p_sel;
            end
            tcske_pkg::ST_EXP: begin
                mul_a = VW'(eb - ea);
                mul_b = PW'(efrac);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        case (r_state)
            tcske_pkg::ST_IDLE:
                if (s_axis_tvalid && s_axis_tready) n_state = tcske_pkg::ST_DIV;
            tcske_pkg::ST_DIV: begin
                if (!r_upd) n_state = tcske_pkg::ST_EXP;
                else begin
                    div_start = 1'b1;
                    n_state   = tcske_pkg::ST_MUL_X;
                end
            end
            tcske_pkg::ST_MUL_X: if (div_done) n_state = tcske_pkg::ST_MUL_P;
            tcske_pkg::ST_MUL_P: n_state = tcske_pkg::ST_EXP;
            tcske_pkg::ST_EXP:   n_state = tcske_pkg::ST_OUT;
            tcske_pkg::ST_OUT:   n_state = tcske_pkg::ST_IDLE;
            default:             n_state = tcske_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tcske_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    assign x_min = (r_x[0] < r_x[1]) ? r_x[0] : r_x[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise  <= tcske_pkg::NOISE_RESET;
            r_x[0]   <= ONE;
            r_x[1]   <= ONE;
            r_x[2]   <= ONE >> 1;
            for (int c = 0; c < 3; c++) r_p[c] <= PW'(ONE >> 1);
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_noise <= i_cfg_wdata;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                tcske_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_r     <= ONE - clamp1(s_axis_tdata[16:0]) + RFLOOR;
                    r_stamp <= s_axis_tdata[98:51];
                    case (s_axis_tuser[1:0])
                        tcske_pkg::CAT_BERTH: begin
                            r_ch  <= 2'd0;
                            r_upd <= 1'b1;
                            r_z   <= ONE - clamp1(s_axis_tdata[33:17]);
                        end
                        tcske_pkg::CAT_CRANE: begin
                            r_ch  <= 2'd1;
                            r_upd <= 1'b1;
                            r_z   <= ONE - clamp1(s_axis_tdata[33:17]);
                        end
                        tcske_pkg::CAT_YARD: begin
                            r_ch  <= 2'd2;
                            r_upd <= s_axis_tuser[2];
                            r_z   <= clamp1(s_axis_tdata[50:34]);
                        end
                        default: begin
                            r_ch  <= 2'd0;
                            r_upd <= 1'b0;
                            r_z   <= ONE - clamp1(s_axis_tdata[33:17]);
                        end
                    endcase
                    for (int c = 0; c < 3; c++)
                        r_p[c] <= p_noisy[c][PW] ? UMAX : p_noisy[c][PW-1:0];
                end
                // gain arrives: move the estimate toward the measurement
                tcske_pkg::ST_MUL_X: if (div_done) begin
                    r_k <= VW'(div_quo);
                    if (r_z >= x_sel) r_x[r_ch] <= x_sel + VW'(mul_y >> FRAC_BITS);
                    else              r_x[r_ch] <= x_sel - VW'(mul_y >> FRAC_BITS);
                end
                // shrink the uncertainty by (1 - gain)
                tcske_pkg::ST_MUL_P: r_p[r_ch] <= PW'(mul_y >> FRAC_BITS);
                default: ;
            endcase
            // finish: throughput and delay from final levels
            if (r_state == tcske_pkg::ST_EXP) begin
                logic [VW-1:0] fs;
                fs = (r_x[2] >= ONE) ? '0 : ONE - r_x[2];
                r_thr <= (fs < x_min) ? fs : x_min;
                if (r_x[2] > YHI)
                    r_delay <= 21'((64'(ONE) << 1) + ea + 64'(mul_y >> FRAC_BITS));
                else if (r_x[1] < (ONE >> 1))
                    r_delay <= 21'((ONE << 1) + 21'(5) * 21'(ONE - r_x[1]));
                else
                    r_delay <= 21'(ONE) << 1;
            end
            if (r_state == tcske_pkg::ST_OUT) r_ovalid <= 1'b1;
        end
    end

    // ready only when idle with no result waiting
    assign s_axis_tready = (r_state == tcske_pkg::ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_stamp, r_delay, 17'(r_thr), 17'(r_x[2]),
                            17'(r_x[1]), 17'(r_x[0])};
endmodule
`default_nettype wire

// File: hdl/tcske_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle
module tcske_div #(
    parameter int NW = 40,
    parameter int DW = 24
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_quo;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   n_shift;

    assign n_shift = {r_rem[DW-1:0], r_quo[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (n_shift >= {1'b0, r_den}) begin
                    r_rem <= n_shift - {1'b0, r_den};
                    r_quo <= {r_quo[NW-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

// File: hdl/tcske_checker.sv
`default_nettype none
module tcske_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [143:0] m_axis_tdata
);
    // no new request while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
    // accepted request is not followed immediately by a result
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("early result");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped");
    // delay never below two days
    a_del: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[88:68] >= 21'd131072)) else $error("delay low");
endmodule
bind three_channel_scalar_kalman_estimator_top tcske_checker u_chk (.*);
`default_nettype wire

// File: tb/three_channel_scalar_kalman_estimator_top_tb.sv
`timescale 1ns / 1ps

module three_channel_scalar_kalman_estimator_top_tb;

    localparam logic [63:0] ONE_FX   = 64'd1 << 16;
    localparam logic [63:0] UNC_SAT  = (64'd1 << 20) - 1;
    localparam logic [63:0] R_MIN    = ONE_FX / 100;
    localparam logic [63:0] YARD_KNEE = (ONE_FX * 9) / 10;

    typedef struct packed {
        logic [47:0] stamp;
        logic [20:0] delay;
        logic [16:0] thr;
        logic [16:0] yard;
        logic [16:0] crane;
        logic [16:0] berth;
    } t_estimate;

    // Tracks the three channel estimates and queues the expected outputs
    class estimate_tracker;
        logic [63:0] noise;
        logic [63:0] berth_x, crane_x, yard_x;
        logic [63:0] berth_p, crane_p, yard_p;
        t_estimate   expected_outputs[$];
        int          mismatches;

        function void restart();
            noise   = 64'(tcske_pkg::NOISE_RESET);
            berth_x = ONE_FX;
            crane_x = ONE_FX;
            yard_x  = ONE_FX / 2;
            berth_p = ONE_FX / 2;
            crane_p = ONE_FX / 2;
            yard_p  = ONE_FX / 2;
            expected_outputs.delete();
            mismatches = 0;
        endfunction

        function void set_noise(logic [16:0] v);
            noise = 64'(v);
        endfunction

        function logic [63:0] sat_one(logic [16:0] v);
            return (64'(v) > ONE_FX) ? ONE_FX : 64'(v);
        endfunction

        function logic [63:0] grow(logic [63:0] p);
            logic [63:0] s;
            s = p + noise;
            return (s > UNC_SAT) ? UNC_SAT : s;
        endfunction

        // one scalar update: gain, move toward z, shrink uncertainty
        function void update(inout logic [63:0] x, inout logic [63:0] p,
                             input logic [63:0] z, input logic [63:0] r);
            logic [63:0] gain;
            gain = (p << 16) / (p + r);
            if (z >= x)
                x = x + ((gain * (z - x)) >> 16);
            else
                x = x - ((gain * (x - z)) >> 16);
            p = (p * (ONE_FX - gain)) >> 16;
        endfunction

        // exp(k/64), Taylor series at 32 fraction bits
        function logic [63:0] exp_at(logic [63:0] k);
            logic [63:0] term, acc, n;
            term = 64'd1 << 32;
            acc  = 0;
            n    = 1;
            while (term != 0 && n < 64) begin
                acc  = acc + term;
                term = (term * k) / (64'(tcske_pkg::EXP_SEGMENTS) * n);
                n    = n + 1;
            end
            return acc >> 16;
        endfunction

        function logic [63:0] exp_interp(logic [63:0] t);
            logic [63:0] scaled, idx, frac, a, b;
            scaled = t * 64'(tcske_pkg::EXP_SEGMENTS);
            idx    = scaled >> 16;
            frac   = scaled & (ONE_FX - 1);
            if (idx > 4 * tcske_pkg::EXP_SEGMENTS) begin
                idx  = 4 * tcske_pkg::EXP_SEGMENTS;
                frac = 0;
            end
            a = exp_at(idx);
            b = exp_at(idx + 1);
            return a + (((b - a) * frac) >> 16);
        endfunction

        function void note_observation(logic [1:0] cat, logic [16:0] rel_in,
                                       logic [16:0] sev_in, logic has_val,
                                       logic [16:0] yv_in, logic [47:0] stamp);
            logic [63:0] rel, sev, yv, r, free_sp, thr, delay;
            t_estimate   e;
            rel = sat_one(rel_in);
            sev = sat_one(sev_in);
            yv  = sat_one(yv_in);
            r   = ONE_FX - rel + R_MIN;
            berth_p = grow(berth_p);
            crane_p = grow(crane_p);
            yard_p  = grow(yard_p);
            case (cat)
                tcske_pkg::CAT_BERTH: update(berth_x, berth_p, ONE_FX - sev, r);
                tcske_pkg::CAT_CRANE: update(crane_x, crane_p, ONE_FX - sev, r);
                tcske_pkg::CAT_YARD:  if (has_val) update(yard_x, yard_p, yv, r);
                default: ;
            endcase
            free_sp = (yard_x >= ONE_FX) ? 0 : ONE_FX - yard_x;
            thr = (berth_x < crane_x) ? berth_x : crane_x;
            if (free_sp < thr) thr = free_sp;
            delay = 2 * ONE_FX;
            if (yard_x > YARD_KNEE)
                delay = delay + exp_interp((yard_x - YARD_KNEE) * 30);
            else if (crane_x < ONE_FX / 2)
                delay = delay + 5 * (ONE_FX - crane_x);
            e.berth = berth_x[16:0];
            e.crane = crane_x[16:0];
            e.yard  = yard_x[16:0];
            e.thr   = thr[16:0];
            e.delay = delay[20:0];
            e.stamp = stamp;
            expected_outputs.push_back(e);
        endfunction

        function void check_output(logic [143:0] data);
            t_estimate e, got;
            got = data[136:0];
            if (expected_outputs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: output with nothing expected: %h", got);
                return;
            end
            e = expected_outputs.pop_front();
            if (got !== e || data[143:137] !== 7'd0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: berth %0d/%0d crane %0d/%0d yard %0d/%0d ",
                              "thr %0d/%0d delay %0d/%0d stamp %h/%h (exp/got)"},
                             e.berth, got.berth, e.crane, got.crane, e.yard, got.yard,
                             e.thr, got.thr, e.delay, got.delay, e.stamp, got.stamp);
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [16:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [143:0] m_axis_tdata;

    estimate_tracker tracker = new();
    bit  idle_on = 1'b1;
    bit  hold_out = 1'b0;
    int  out_stall = 0;
    int  accepted = 0;

    three_channel_scalar_kalman_estimator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: random stall per output, plus the long hold-off
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_out || out_stall > 0) begin
                m_axis_tready = 1'b0;
                if (out_stall > 0) out_stall--;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_output(m_axis_tdata);
            out_stall = idle_on ? $urandom_range(0, 4) : 0;
        end
    end

    // hold the output off for a long stretch once traffic is running
    initial begin
        wait (accepted >= 300);
        @(negedge i_clk);
        hold_out = 1'b1;
        repeat (500) @(posedge i_clk);
        @(negedge i_clk);
        hold_out = 1'b0;
    end

    task automatic send_obs(input logic [1:0] cat, input logic [16:0] rel,
                            input logic [16:0] sev, input logic has_val,
                            input logic [16:0] yv, input logic [47:0] stamp);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        s_axis_tdata  = {5'd0, stamp, yv, sev, rel};
        s_axis_tuser  = {has_val, cat};
        s_axis_tvalid = 1'b1;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        tracker.note_observation(cat, rel, sev, has_val, yv, stamp);
        accepted++;
    endtask

    // register write only once the pipeline has drained
    task automatic write_noise(input logic [16:0] v);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait (tracker.expected_outputs.size() == 0);
        repeat (60) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        tracker.set_noise(v);
    endtask

    function automatic logic [16:0] rand_frac();
        if ($urandom_range(0, 9) == 0) return 17'($urandom);
        return 17'($urandom_range(0, 65536));
    endfunction

    task automatic random_obs(int count);
        logic [1:0]  cat;
        logic [16:0] sev, yv;
        for (int i = 0; i < count; i++) begin
            cat = 2'($urandom_range(0, 3));
            sev = ($urandom_range(0, 2) == 0) ? 17'($urandom_range(50000, 65536))
                                              : rand_frac();
            yv  = ($urandom_range(0, 1) == 0) ? 17'($urandom_range(58000, 65536))
                                              : rand_frac();
            send_obs(cat, rand_frac(), sev, 1'($urandom_range(0, 3) != 0), yv,
                     48'({$urandom, $urandom}));
        end
    endtask

    initial begin
        tracker.restart();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, every category, saturation, yard without value
        idle_on = 1'b0;
        send_obs(tcske_pkg::CAT_NONE, 17'd0, 17'd0, 1'b0, 17'd0, 48'd0);
        send_obs(tcske_pkg::CAT_BERTH, 17'd65536, 17'd65536, 1'b0, 17'd0, '1);
        send_obs(tcske_pkg::CAT_BERTH, 17'h1FFFF, 17'h1FFFF, 1'b1, 17'h1FFFF, 48'h1);
        send_obs(tcske_pkg::CAT_BERTH, 17'd0, 17'd0, 1'b0, 17'd0, 48'h800000000000);
        send_obs(tcske_pkg::CAT_YARD, 17'd65536, 17'd0, 1'b0, 17'd0, 48'h5);
        for (int i = 0; i < 6; i++)
            send_obs(tcske_pkg::CAT_CRANE, 17'h1FFFF, 17'd65536, 1'b0, 17'd0, 48'(i));
        for (int i = 0; i < 6; i++)
            send_obs(tcske_pkg::CAT_YARD, 17'd65536, 17'd0, 1'b1, 17'h1FFFF,
                     48'(100 + i));
        send_obs(tcske_pkg::CAT_YARD, 17'd0, 17'd0, 1'b1, 17'd0, 48'h7);
        send_obs(tcske_pkg::CAT_CRANE, 17'd65536, 17'd0, 1'b0, 17'd0, 48'h8);
        idle_on = 1'b1;

        // noise at zero, then at its top so the uncertainties saturate
        write_noise(17'd0);
        random_obs(250);
        write_noise(17'd65536);
        random_obs(350);
        write_noise(17'(tcske_pkg::NOISE_RESET));
        random_obs(450);
        idle_on = 1'b0;
        random_obs(100);
        idle_on = 1'b1;
        write_noise(17'($urandom_range(0, 65536)));
        random_obs(350);

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait (tracker.expected_outputs.size() == 0);
        repeat (60) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.expected_outputs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: three_channel_scalar_kalman_estimator_top.f
hdl/tcske_pkg.sv
hdl/tcske_div.sv
hdl/three_channel_scalar_kalman_estimator_top.sv
hdl/tcske_checker.sv
tb/three_channel_scalar_kalman_estimator_top_tb.sv
